// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the hashing block
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent checked in the same cycle.
`define SHA1_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha1 same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define SHA1_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha1 next-cycle check failed");

`endif

// ===== hdl/sha1_pkg.sv =====
// ---------------------------------------------------------------------------
// sha1_pkg
// Types and constants shared by the SHA-1 controller, datapath and top level.
// ---------------------------------------------------------------------------
package sha1_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned WIDX_W     = 3;
  localparam int unsigned COUNT_W    = 61;
  localparam int unsigned FILL_W     = 6;
  localparam int unsigned ROUND_W    = 7;
  localparam int unsigned CHAIN_N    = 5;
  localparam int unsigned SCHED_N    = 16;

  localparam logic [WIDX_W-1:0]  DIGEST_LAST = 3'd4;
  localparam logic [FILL_W-1:0]  FILL_LAST   = 6'd63;
  localparam logic [FILL_W-1:0]  FILL_LEN    = 6'd56;
  localparam logic [ROUND_W-1:0] ROUND_SCHED = 7'd16;
  localparam logic [ROUND_W-1:0] ROUND_PAR1  = 7'd20;
  localparam logic [ROUND_W-1:0] ROUND_MAJ   = 7'd40;
  localparam logic [ROUND_W-1:0] ROUND_PAR2  = 7'd60;
  localparam logic [ROUND_W-1:0] ROUND_LAST  = 7'd79;

  localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;

  localparam logic [WORD_W-1:0] K_CH   = 32'h5A827999;
  localparam logic [WORD_W-1:0] K_PAR1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K_MAJ  = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K_PAR2 = 32'hCA62C1D6;

  localparam logic [WORD_W-1:0] H_INIT [CHAIN_N] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  typedef enum logic [1:0] {
    SRC_IN,
    SRC_MARK,
    SRC_ZERO,
    SRC_LEN
  } byte_src_t;

  typedef struct packed {
    logic              put;        // push one byte into the block
    byte_src_t         byte_src;
    logic [2:0]        len_sel;    // length byte, 7 is most significant
    logic              count_inc;  // byte belongs to the message
    logic              round_en;   // run one compression round
    logic              chain_add;  // fold working vars into chain value
    logic [WIDX_W-1:0] word_sel;   // digest word on the output
    logic              restart;    // back to initial chain for next message
  } sha1_cmd_t;

  typedef struct packed {
    logic fill_full;   // next byte completes the block
    logic fill_len;    // block holds 56 bytes, length goes next
    logic round_last;  // round 79 in progress
  } sha1_status_t;

endpackage

// ===== hdl/sha1_ifs.sv =====
// ---------------------------------------------------------------------------
// sha1 channel interfaces
// Byte input channel and digest word output channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface sha1_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output has_byte, output is_last,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input is_last,
                output ready);
endinterface

interface sha1_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

// ===== hdl/sha1_ctrl.sv =====
// ---------------------------------------------------------------------------
// sha1_ctrl
// Sequencer: byte intake, padding, compression rounds and digest output.
// ---------------------------------------------------------------------------
module sha1_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_has_byte,
  input  logic                   in_is_last,
  output logic                   in_ready,
  output logic                   out_valid,
  output logic [2:0]             out_word_index,
  output logic                   out_last_word,
  input  logic                   out_ready,
  input  sha1_pkg::sha1_status_t status,
  output sha1_pkg::sha1_cmd_t    cmd
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_ADD,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    P_MARK,
    P_ZERO,
    P_LEN,
    P_DONE
  } pad_t;

  state_t            state_r, state_nxt;
  pad_t              pad_r, pad_nxt;
  logic [2:0]        len_r, len_nxt;
  logic [WIDX_W-1:0] word_r, word_nxt;
  logic              last_r, last_nxt;   // message end seen, padding under way

  always_comb begin
    state_nxt = state_r;
    pad_nxt   = pad_r;
    len_nxt   = len_r;
    word_nxt  = word_r;
    last_nxt  = last_r;
    cmd       = '0;
    cmd.byte_src = SRC_IN;
    cmd.len_sel  = len_r;
    cmd.word_sel = word_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          pad_nxt  = P_MARK;
          last_nxt = in_is_last;
          if (in_has_byte) begin
            cmd.put       = 1'b1;
            cmd.count_inc = 1'b1;
          end
          if (in_has_byte && status.fill_full) begin
            state_nxt = S_COMP;
          end else if (in_is_last) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        case (pad_r)
          P_MARK: begin
            cmd.put      = 1'b1;
            cmd.byte_src = SRC_MARK;
            pad_nxt      = P_ZERO;
          end
          P_ZERO: begin
            if (status.fill_len) begin
              pad_nxt = P_LEN;
              len_nxt = 3'd7;
            end else begin
              cmd.put      = 1'b1;
              cmd.byte_src = SRC_ZERO;
            end
          end
          P_LEN: begin
            cmd.put      = 1'b1;
            cmd.byte_src = SRC_LEN;
            len_nxt      = len_r - 3'd1;
            if (len_r == 3'd0) begin
              pad_nxt = P_DONE;
            end
          end
          default: begin
          end
        endcase
        if (cmd.put && status.fill_full) begin
          state_nxt = S_COMP;
        end
      end
      S_COMP: begin
        cmd.round_en = 1'b1;
        if (status.round_last) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.chain_add = 1'b1;
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (pad_r == P_DONE) begin
          state_nxt = S_OUT;
          word_nxt  = '0;
        end else begin
          state_nxt = S_PAD;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (word_r == DIGEST_LAST) begin
            cmd.restart = 1'b1;
            last_nxt    = 1'b0;
            state_nxt   = S_IDLE;
          end else begin
            word_nxt = word_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_word_index = word_r;
  assign out_last_word  = (word_r == DIGEST_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pad_r   <= P_MARK;
      len_r   <= '0;
      word_r  <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pad_r   <= pad_nxt;
      len_r   <= len_nxt;
      word_r  <= word_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

// ===== hdl/sha1_dp.sv =====
// ---------------------------------------------------------------------------
// sha1_dp
// Byte packer, 16-word schedule shift line, round logic and chain value.
// ---------------------------------------------------------------------------
module sha1_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sha1_pkg::sha1_cmd_t    cmd,
  input  logic [7:0]             data_byte,
  output sha1_pkg::sha1_status_t status,
  output logic [31:0]            digest_word
);
  import sha1_pkg::*;

  logic [WORD_W-1:0]  w_r [SCHED_N];   // w_r[0] is the oldest word
  logic [23:0]        acc_r;           // first three bytes of the word in progress
  logic [WORD_W-1:0]  a_r, b_r, c_r, d_r, e_r;
  logic [WORD_W-1:0]  chain_r [CHAIN_N];
  logic [COUNT_W-1:0] count_r;
  logic [FILL_W-1:0]  fill_r;
  logic [ROUND_W-1:0] round_r;

  logic [BYTE_W-1:0]  put_byte;
  logic [63:0]        len_bits;
  logic [WORD_W-1:0]  sched_x, wt, f, k, t;

  assign len_bits = {count_r, 3'b000};

  always_comb begin
    case (cmd.byte_src)
      SRC_IN:   put_byte = data_byte;
      SRC_MARK: put_byte = PAD_MARK;
      SRC_LEN:  put_byte = len_bits[{cmd.len_sel, 3'b000} +: 8];
      default:  put_byte = '0;
    endcase
  end

  assign sched_x = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign wt = (round_r < ROUND_SCHED) ? w_r[0] : {sched_x[30:0], sched_x[31]};

  always_comb begin
    if (round_r < ROUND_PAR1) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = K_CH;
    end else if (round_r < ROUND_MAJ) begin
      f = b_r ^ c_r ^ d_r;
      k = K_PAR1;
    end else if (round_r < ROUND_PAR2) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = K_MAJ;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = K_PAR2;
    end
  end

  assign t = {a_r[26:0], a_r[31:27]} + f + e_r + wt + k;

  always_comb begin
    case (cmd.word_sel)
      3'd0:    digest_word = chain_r[0];
      3'd1:    digest_word = chain_r[1];
      3'd2:    digest_word = chain_r[2];
      3'd3:    digest_word = chain_r[3];
      3'd4:    digest_word = chain_r[4];
      default: digest_word = '0;
    endcase
  end

  assign status.fill_full  = (fill_r == FILL_LAST);
  assign status.fill_len   = (fill_r == FILL_LEN);
  assign status.round_last = (round_r == ROUND_LAST);

  // schedule line and working variables
  always_ff @(posedge clk) begin
    if (cmd.put) begin
      acc_r <= {acc_r[15:0], put_byte};
      if (fill_r[1:0] == 2'b11) begin
        for (int i = 0; i < SCHED_N - 1; i++) begin
          w_r[i] <= w_r[i+1];
        end
        w_r[SCHED_N-1] <= {acc_r, put_byte};
      end
      if (fill_r == FILL_LAST) begin
        a_r <= chain_r[0];
        b_r <= chain_r[1];
        c_r <= chain_r[2];
        d_r <= chain_r[3];
        e_r <= chain_r[4];
      end
    end else if (cmd.round_en) begin
      for (int i = 0; i < SCHED_N - 1; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[SCHED_N-1] <= wt;
      e_r <= d_r;
      d_r <= c_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      b_r <= a_r;
      a_r <= t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHAIN_N; i++) begin
        chain_r[i] <= H_INIT[i];
      end
      count_r <= '0;
      fill_r  <= '0;
      round_r <= '0;
    end else if (cmd.restart) begin
      for (int i = 0; i < CHAIN_N; i++) begin
        chain_r[i] <= H_INIT[i];
      end
      count_r <= '0;
      fill_r  <= '0;
      round_r <= '0;
    end else begin
      if (cmd.chain_add) begin
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
        chain_r[4] <= chain_r[4] + e_r;
      end
      if (cmd.count_inc) begin
        count_r <= count_r + 61'd1;
      end
      if (cmd.put) begin
        fill_r <= fill_r + 6'd1;
      end
      if (cmd.put && (fill_r == FILL_LAST)) begin
        round_r <= '0;
      end else if (cmd.round_en) begin
        round_r <= round_r + 7'd1;
      end
    end
  end

endmodule

// ===== hdl/sha1_message_hasher_top.sv =====
// ---------------------------------------------------------------------------
// sha1_message_hasher_top
// SHA-1 hasher over a byte stream, digest returned as five 32-bit words.
// ---------------------------------------------------------------------------
// Input channel in_ch carries one message byte per item (has_byte qualifies
// data_byte, is_last ends the message). An item with neither flag is dropped.
// Output channel out_ch returns the digest as five items, word_index 0 first,
// last_word set on word 4. Both use valid/ready; transfer when both are high.
// Every 64th byte starts the compression: 80 rounds, one per cycle on the
// single round adder, plus a chain update step, so input stalls for each
// block. On is_last the padding is fed through the byte packer at one byte
// per cycle outside compressions (9 to 72 bytes, plus an idle step before
// the length bytes), with one or two compressions, then the five words are
// offered one per cycle. Input is held off while a message is being
// finished; a stalled receiver holds the current word on out_ch.
// After the last word the block takes the next message at once.
// Reset (rst_n low, synchronous) loads the initial chain value and clears
// the byte count; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sha1_message_hasher_top (
  input  logic          clk,
  input  logic          rst_n,
  sha1_byte_if.sink     in_ch,
  sha1_digest_if.source out_ch
);
  import sha1_pkg::*;

  sha1_cmd_t    cmd;
  sha1_status_t status;

  sha1_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_has_byte    (in_ch.has_byte),
    .in_is_last     (in_ch.is_last),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_word_index (out_ch.word_index),
    .out_last_word  (out_ch.last_word),
    .out_ready      (out_ch.ready),
    .status         (status),
    .cmd            (cmd)
  );

  sha1_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_ch.data_byte),
    .status      (status),
    .digest_word (out_ch.digest_word)
  );

  `SHA1_ASSERT_SAME(a_no_intake_during_output, clk, rst_n, out_ch.valid, !in_ch.ready)
  `SHA1_ASSERT_SAME(a_last_word_is_four, clk, rst_n, out_ch.valid && out_ch.last_word, out_ch.word_index == DIGEST_LAST)
  `SHA1_ASSERT_NEXT(a_add_after_last_round, clk, rst_n, cmd.round_en && status.round_last, cmd.chain_add)
  `SHA1_ASSERT_NEXT(a_ready_after_digest, clk, rst_n, out_ch.valid && out_ch.ready && out_ch.last_word, in_ch.ready)

endmodule

// ===== tb/tb_sha1_message_hasher_top.sv =====
// ---------------------------------------------------------------------------
// tb_sha1_message_hasher_top
// Streams byte messages into the SHA-1 hasher and checks every digest word
// against a SHA-1 computed alongside in the testbench. Covers empty items,
// empty messages, one- and two-block padding, and stalls on both channels,
// including a long receiver hold-off that backs up the input.
// ---------------------------------------------------------------------------
module tb_sha1_message_hasher_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ITEMS = 300;
  localparam int QUIET_ITEMS = 60;   // no idling for the final stretch
  localparam int LONG_HOLD = 400;
  localparam int TAIL_CYCLES = 250;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    bit [31:0] word;
    bit [2:0]  idx;
    bit        last;
  } digest_word_t;

  class sha1_digest_tracker;
    bit [31:0]    blk[16];
    bit [31:0]    chain[5];
    bit [60:0]    byte_cnt;
    bit [5:0]     fill;
    digest_word_t digest_words_due[$];
    int           fail_count;
    int           n_msgs;
    int           n_bytes;
    int           n_words;
    int           cur_len;
    int           max_len;

    function new();
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 5; i++) chain[i] = sha1_pkg::H_INIT[i];
      byte_cnt = '0;
      fill = '0;
    endfunction

    function bit [31:0] rol(bit [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function void compress_block();
      bit [31:0] w[16];
      bit [31:0] a, b, c, d, e, f, k, t, wt;
      w = blk;
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int r = 0; r < 80; r++) begin
        if (r < 16) begin
          wt = w[r];
        end else begin
          wt = rol(w[(r + 13) & 15] ^ w[(r + 8) & 15] ^ w[(r + 2) & 15] ^ w[r & 15], 1);
          w[r & 15] = wt;
        end
        if (r < 20) begin
          f = (b & c) | (~b & d);
          k = sha1_pkg::K_CH;
        end else if (r < 40) begin
          f = b ^ c ^ d;
          k = sha1_pkg::K_PAR1;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = sha1_pkg::K_MAJ;
        end else begin
          f = b ^ c ^ d;
          k = sha1_pkg::K_PAR2;
        end
        t = rol(a, 5) + f + e + wt + k;
        e = d; d = c; c = rol(b, 30); b = a; a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endfunction

    // big-endian packing; compress once 64 bytes are in
    function void put_byte(bit [7:0] v);
      blk[fill[5:2]][31 - 8 * fill[1:0] -: 8] = v;
      fill++;
      if (fill == 6'd0) compress_block();
    endfunction

    function void take_item(bit [7:0] data, bit has, bit last);
      bit [63:0]    bit_len;
      digest_word_t dw;
      if (has) begin
        put_byte(data);
        byte_cnt++;
        n_bytes++;
        cur_len++;
      end
      if (!last) return;
      bit_len = {byte_cnt, 3'b000};
      put_byte(sha1_pkg::PAD_MARK);
      while (fill != sha1_pkg::FILL_LEN) put_byte(8'h00);
      for (int i = 7; i >= 0; i--) put_byte(bit_len[8 * i +: 8]);
      for (int i = 0; i < 5; i++) begin
        dw.word = chain[i];
        dw.idx = i[2:0];
        dw.last = (i == 4);
        digest_words_due.push_back(dw);
      end
      n_msgs++;
      if (cur_len > max_len) max_len = cur_len;
      cur_len = 0;
      restart();
    endfunction

    task report_mismatch(string msg);
      fail_count++;
      $display("MISMATCH at %0t ns: %s", $realtime, msg);
    endtask

    task check_word(bit [31:0] word, bit [2:0] idx, bit last);
      digest_word_t dw;
      if (digest_words_due.size() == 0) begin
        report_mismatch($sformatf("unexpected digest word %08h index %0d", word, idx));
        return;
      end
      dw = digest_words_due.pop_front();
      n_words++;
      if (word != dw.word)
        report_mismatch($sformatf("word %0d: got %08h, want %08h", dw.idx, word, dw.word));
      if (idx != dw.idx)
        report_mismatch($sformatf("word_index: got %0d, want %0d", idx, dw.idx));
      if (last != dw.last)
        report_mismatch($sformatf("last_word on word %0d: got %0b, want %0b",
                                  dw.idx, last, dw.last));
    endtask

    function int words_due();
      return digest_words_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  sha1_byte_if   in_ch();
  sha1_digest_if out_ch();

  sha1_message_hasher_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  sha1_digest_tracker sb;
  int items_sent = 0;
  bit quiet = 1'b0;
  bit hold_request = 1'b0;
  int cycle_cnt = 0;

  task automatic send_item(input bit [7:0] d, input bit h, input bit l);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.has_byte <= h;
    in_ch.is_last <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_item(d, h, l);
    if (h || l) items_sent++;
    if (items_sent >= NUM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
  endtask

  // random bytes; ends either on the last byte or with a separate end item
  task automatic send_message(input int len);
    bit end_on_byte;
    end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  initial begin : stimulus
    int boundary_lens[3];
    int len;
    sb = new();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= 8'h00;
    in_ch.has_byte <= 1'b0;
    in_ch.is_last <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty message, lone bytes at the extremes, "abc" both ways,
    // empty items inside and between messages
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'hAA, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b1);

    // receiver holds off while the next messages pile up behind it
    hold_request = 1'b1;

    // padding edges: one final block, two final blocks, a full block in the message
    boundary_lens = '{55, 56, 64};
    boundary_lens.shuffle();
    send_message($urandom_range(0, 20));
    foreach (boundary_lens[i]) send_message(boundary_lens[i]);

    while (items_sent < NUM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) len = $urandom_range(50, 70);
      else len = $urandom_range(0, 20);
      send_message(len);
    end
    in_ch.valid <= 1'b0;

    while (sb.words_due() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Hashed %0d messages, %0d bytes in all (longest %0d), in %0d cycles.",
             sb.n_msgs, sb.n_bytes, sb.max_len, cycle_cnt);
    $display("Checked %0d digest words, %0d mismatches.", sb.n_words, sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : digest_sink
    int stall_cnt;
    stall_cnt = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_word(out_ch.digest_word, out_ch.word_index, out_ch.last_word);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_cnt = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && rst_n && $urandom_range(0, 4) == 0) begin
        stall_cnt = $urandom_range(1, 7) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= rst_n;
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles, %0d digest words still due.",
             cycle_cnt, sb.words_due());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/sha1_pkg.sv
hdl/sha1_ifs.sv
hdl/sha1_ctrl.sv
hdl/sha1_dp.sv
hdl/sha1_message_hasher_top.sv
tb/tb_sha1_message_hasher_top.sv
